@@ hw/rtl/kppu_pkg.sv @@
package kppu_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int RANK_W       = 45;
    localparam int CNT_W        = 5;
    localparam int IDX_W        = 4;
    localparam int ELEM_W       = 16;
    localparam int QBITS        = 4;
    localparam int BIT_W        = 2;
    localparam int IN_W         = 56;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture an input item and fill the working copy
        logic mul_step;  // multiply the product by the running factor
        logic d_setup;   // start the divisor product for the current position
        logic div_step;  // one restoring division step
        logic emit;      // rotate the pick to the front and load the output
        logic emit_err;  // load the error item
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad;       // pick count zero, above set size or set too large
        logic mul_done;  // no factors left in the product
        logic rank_ok;   // rank below the full falling factorial
        logic div_last;  // the current division step is the final one
        logic out_free;  // output register can take an item this cycle
        logic last_pick; // the current position is the final one
    } status_t;

endpackage

@@ hw/rtl/kppu_ctrl.sv @@
module kppu_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  kppu_pkg::status_t status,
    output kppu_pkg::cmd_t    cmd
);
    import kppu_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHK   = 3'd1;
    localparam logic [2:0] ST_PROD  = 3'd2;
    localparam logic [2:0] ST_DSET  = 3'd3;
    localparam logic [2:0] ST_DPROD = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;
    localparam logic [2:0] ST_ERR   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                state_next = status.bad ? ST_ERR : ST_PROD;
            end
            ST_PROD:
            begin
                if (status.mul_done)
                begin
                    state_next = status.rank_ok ? ST_DSET : ST_ERR;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_DSET:
            begin
                cmd.d_setup = 1'b1;
                state_next  = ST_DPROD;
            end
            ST_DPROD:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.last_pick ? ST_IDLE : ST_DSET;
                end
            end
            ST_ERR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/kppu_dp.sv @@
module kppu_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [kppu_pkg::RANK_W-1:0]     in_rank,
    input  logic [kppu_pkg::CNT_W-1:0]      in_set_size,
    input  logic [kppu_pkg::CNT_W-1:0]      in_pick_count,
    input  logic                            cfg_we,
    input  logic [kppu_pkg::ELEM_W-1:0]     cfg_base,
    input  kppu_pkg::cmd_t                  cmd,
    output kppu_pkg::status_t               status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [kppu_pkg::ELEM_W-1:0]     out_element,
    output logic                            out_last,
    output logic                            out_error
);
    import kppu_pkg::*;

    logic [ELEM_W-1:0]       base_reg;
    logic [RANK_W-1:0]       t_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        r_reg;
    logic [CNT_W-1:0]        k_reg;
    logic [CNT_W-1:0]        m_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [RANK_W-1:0]       p_reg;
    logic [QBITS-1:0]        q_reg;
    logic [BIT_W-1:0]        b_reg;
    logic [ELEM_W-1:0]       ws_reg [MAX_ELEMENTS];
    logic                    out_valid_reg;
    logic [ELEM_W-1:0]       out_elem_reg;
    logic                    out_last_reg;
    logic                    out_err_reg;

    logic [RANK_W+CNT_W-1:0] prod;
    logic [RANK_W+QBITS-1:0] shifted;
    logic                    fits;
    logic [CNT_W-1:0]        pick_idx;
    logic [ELEM_W-1:0]       pick;

    // Shared arithmetic: one narrow multiply and one compare-subtract.
    assign prod     = p_reg * m_reg;
    assign shifted  = {{QBITS{1'b0}}, p_reg} << b_reg;
    assign fits     = {{QBITS{1'b0}}, t_reg} >= shifted;
    assign pick_idx = k_reg + {1'b0, q_reg};
    assign pick     = ws_reg[pick_idx[IDX_W-1:0]];

    assign status.bad       = (r_reg == '0) || (r_reg > n_reg)
                              || (n_reg > CNT_W'(MAX_ELEMENTS));
    assign status.mul_done  = (cnt_reg == '0);
    assign status.rank_ok   = (t_reg < p_reg);
    assign status.div_last  = (b_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.last_pick = ((k_reg + CNT_W'(1)) == r_reg);

    assign out_valid   = out_valid_reg;
    assign out_element = out_elem_reg;
    assign out_last    = out_last_reg;
    assign out_error   = out_err_reg;

    // Control registers: base value and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_base;
            end
            if (cmd.emit || cmd.emit_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the unranking loop.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg   <= in_rank;
            n_reg   <= in_set_size;
            r_reg   <= in_pick_count;
            k_reg   <= '0;
            m_reg   <= in_set_size;
            cnt_reg <= in_pick_count;
            p_reg   <= RANK_W'(1);
            for (int j = 0; j < MAX_ELEMENTS; j++)
            begin
                ws_reg[j] <= base_reg + ELEM_W'(j);
            end
        end
        if (cmd.mul_step)
        begin
            p_reg   <= prod[RANK_W-1:0];
            m_reg   <= m_reg - CNT_W'(1);
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.d_setup)
        begin
            p_reg   <= RANK_W'(1);
            m_reg   <= n_reg - k_reg - CNT_W'(1);
            cnt_reg <= r_reg - k_reg - CNT_W'(1);
            q_reg   <= '0;
            b_reg   <= BIT_W'(QBITS - 1);
        end
        if (cmd.div_step)
        begin
            if (fits)
            begin
                t_reg        <= t_reg - shifted[RANK_W-1:0];
                q_reg[b_reg] <= 1'b1;
            end
            b_reg <= b_reg - BIT_W'(1);
        end
        // Rotate the pick to the front of the unused part.
        if (cmd.emit)
        begin
            for (int j = 0; j < MAX_ELEMENTS; j++)
            begin
                if (CNT_W'(j) == k_reg)
                begin
                    ws_reg[j] <= pick;
                end
                else if ((CNT_W'(j) > k_reg) && (CNT_W'(j) <= pick_idx) && (j > 0))
                begin
                    ws_reg[j] <= ws_reg[(j > 0) ? j - 1 : 0];
                end
            end
            k_reg        <= k_reg + CNT_W'(1);
            out_elem_reg <= pick;
            out_last_reg <= status.last_pick;
            out_err_reg  <= 1'b0;
        end
        if (cmd.emit_err)
        begin
            out_elem_reg <= '0;
            out_last_reg <= 1'b1;
            out_err_reg  <= 1'b1;
        end
    end

endmodule

@@ hw/rtl/kth_partial_permutation_unrank.sv @@
// Partial permutation unranking.
// An input item on the s_axis channel carries a rank t, a set size n and a
// pick count r. The block returns the t-th r-permutation, in lexicographic
// order, of base_value, base_value+1, ..., base_value+n-1, one element per
// output item on the m_axis channel; tlast marks the r-th element.
// A request with r zero, r above n, n above 16 or t not below P(n,r) gives
// a single output item with element zero, tlast high and tuser (error) high.
// base_value is written through the cfg channel, which is always ready, and
// should only be changed while the block is idle.
// Items are handled one at a time. An item is accepted, checked and its rank
// compared with P(n,r); then for each pick there is a set-up step, the divisor
// product, four restoring division steps and one rotate step, and only after
// the last pick can the next item be accepted. The shared multiplier and the
// four-step divider set how long an item takes.
// The result register lets the next pick be prepared while an element waits;
// a stalled receiver simply holds the block in its emit step.
// Reset clears the state machine, the output valid and base_value to zero.
module kth_partial_permutation_unrank
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // rank [44:0], set_size [49:45], pick_count [54:50]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // element [15:0]
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser,  // error [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data       // base_value [15:0]
);
    import kppu_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    err;

    assign cfg_ready       = 1'b1;
    assign m_axis_tuser[0] = err;

    kppu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kppu_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_rank       (s_axis_tdata[44:0]),
        .in_set_size   (s_axis_tdata[49:45]),
        .in_pick_count (s_axis_tdata[54:50]),
        .cfg_we        (cfg_valid),
        .cfg_base      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_element   (m_axis_tdata),
        .out_last      (m_axis_tlast),
        .out_error     (err)
    );

endmodule

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kppu_pkg::*;

    // One input item and one result item as the block sees them.
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [CNT_W-1:0]  set_size;
        logic [CNT_W-1:0]  pick_count;
    } request_t;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              last;
        logic              error;
    } pick_t;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    request_t          pending_requests[$];
    pick_t             expected_picks[$];
    logic [ELEM_W-1:0] base_value;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                failures;
    int                picks_checked;
    int                requests_sent;
    int                rejects_seen;
    longint            cycle_count;

    kth_partial_permutation_unrank DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Falling factorial m * (m-1) * ... * (m-k+1).
    function automatic longint unsigned falling_product(int m, int k);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < k && i < m; i++)
            p = p * longint'(m - i);
        return p;
    endfunction

    // Work out the picks that one request gives and queue them.
    function automatic void unrank_request(request_t req);
        logic [ELEM_W-1:0] seq[MAX_ELEMENTS];
        longint unsigned   t;
        longint unsigned   d;
        longint unsigned   q;
        int                n;
        int                r;
        int                qi;
        logic [ELEM_W-1:0] chosen;
        pick_t             p;
        t = req.rank;
        n = req.set_size;
        r = req.pick_count;
        if (r == 0 || r > n || n > MAX_ELEMENTS || t >= falling_product(n, r))
        begin
            p.element = '0;
            p.last = 1'b1;
            p.error = 1'b1;
            expected_picks.push_back(p);
            return;
        end
        for (int j = 0; j < n; j++)
            seq[j] = base_value + ELEM_W'(j);
        for (int k = 0; k < r; k++)
        begin
            d = falling_product(n - k - 1, r - k - 1);
            q = t / d;
            t = t % d;
            if (q >= longint'(n - k))
                q = n - k - 1;
            qi = int'(q);
            chosen = seq[k + qi];
            for (int j = k + qi; j > k; j--)
                seq[j] = seq[j - 1];
            seq[k] = chosen;
            p.element = chosen;
            p.last = (k + 1 == r);
            p.error = 1'b0;
            expected_picks.push_back(p);
        end
    endfunction

    function automatic request_t make_request(longint unsigned t, int n, int r);
        request_t req;
        req.rank = t[RANK_W-1:0];
        req.set_size = n[CNT_W-1:0];
        req.pick_count = r[CNT_W-1:0];
        return req;
    endfunction

    // Random request: mostly valid ones with small sizes, some rejects.
    function automatic request_t random_request();
        int              n;
        int              r;
        int              sel;
        longint unsigned lim;
        logic [63:0]     raw;
        sel = $urandom_range(99);
        if (sel < 8)
        begin
            raw = {$urandom, $urandom};
            return make_request(raw, $urandom_range(31), $urandom_range(31));
        end
        n = (sel < 20) ? $urandom_range(16) : $urandom_range(8);
        r = (n == 0) ? 0 : $urandom_range(1, n);
        lim = falling_product(n, r);
        raw = {$urandom, $urandom};
        if (sel < 14)
            return make_request(lim + raw[3:0], n, r);
        if (sel < 30)
            return make_request(lim - 1 - (raw % (lim < 4 ? lim : 4)), n, r);
        return make_request(raw % lim, n, r);
    endfunction

    // Sender: offers the queued requests, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                requests_sent <= requests_sent + 1;
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tdata <= {1'b0, pending_requests[0].pick_count,
                                 pending_requests[0].set_size, pending_requests[0].rank};
                unrank_request(pending_requests.pop_front());
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at random and checks each result item.
    always @(posedge clk or negedge rst_n)
    begin
        pick_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                picks_checked <= picks_checked + 1;
                if (expected_picks.size() == 0)
                begin
                    $error("result item with nothing expected: element %0d", m_axis_tdata);
                    failures = failures + 1;
                end
                else
                begin
                    want = expected_picks.pop_front();
                    if (want.error)
                        rejects_seen <= rejects_seen + 1;
                    if (m_axis_tdata !== want.element)
                    begin
                        $error("element: expected %0d, got %0d", want.element, m_axis_tdata);
                        failures = failures + 1;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                        failures = failures + 1;
                    end
                    if (m_axis_tuser[0] !== want.error)
                    begin
                        $error("error: expected %0b, got %0b", want.error, m_axis_tuser[0]);
                        failures = failures + 1;
                    end
                end
            end
        end
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Wait until every queued request has gone and every result has come.
    task automatic drain();
        while (pending_requests.size() > 0 || s_axis_tvalid || expected_picks.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // Write base_value while the block is idle.
    task automatic write_base(logic [15:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        base_value = value;
    endtask

    initial
    begin
        int idle_send[4];
        int idle_recv[4];
        logic [15:0] bases[4];
        idle_send = '{0, 88, 0, 23};
        idle_recv = '{0, 0, 88, 23};
        bases = '{16'd0, 16'hFFFF, 16'hFFF0, 16'd1234};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        base_value = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        failures = 0;
        picks_checked = 0;
        requests_sent = 0;
        rejects_seen = 0;
        cycle_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset base value.
        pending_requests.push_back(make_request(0, 1, 1));
        pending_requests.push_back(make_request(0, 16, 16));
        pending_requests.push_back(make_request(45'd20922789887999, 16, 16));
        pending_requests.push_back(make_request(45'd20922789888000, 16, 16));
        pending_requests.push_back(make_request(45'h1FFF_FFFF_FFFF, 16, 16));
        pending_requests.push_back(make_request(0, 5, 0));
        pending_requests.push_back(make_request(0, 3, 4));
        pending_requests.push_back(make_request(0, 17, 1));
        pending_requests.push_back(make_request(0, 31, 31));
        pending_requests.push_back(make_request(0, 0, 0));
        pending_requests.push_back(make_request(15, 16, 1));
        pending_requests.push_back(make_request(16, 16, 1));
        pending_requests.push_back(make_request(5, 3, 3));
        pending_requests.push_back(make_request(6, 3, 3));
        pending_requests.push_back(make_request(12345, 10, 5));
        pending_requests.push_back(make_request(523, 16, 3));
        drain();

        // Random phases, each with its own base value and idling pattern.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_base(bases[ph]);
            send_idle_pct = idle_send[ph];
            recv_stall_pct = idle_recv[ph];
            if (ph == 1)
            begin
                pending_requests.push_back(make_request(0, 16, 16));
                pending_requests.push_back(make_request(45'd20922789887999, 16, 16));
            end
            for (int i = 0; i < 92; i++)
                pending_requests.push_back(random_request());
            drain();
        end

        $display("%0d requests sent, %0d result items checked, %0d rejects",
                 requests_sent, picks_checked, rejects_seen);
        $display("four base values including both ends, four handshake idling patterns");
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/kppu_pkg.sv
hw/rtl/kppu_ctrl.sv
hw/rtl/kppu_dp.sv
hw/rtl/kth_partial_permutation_unrank.sv
tb/tb.sv
